[rtl/core/ppfc_pkg.sv]
// Package for the packed pixel format converter.
// Holds the item and configuration types, the codes and the reset values.
// No dependencies; every other file of the block imports it.
package ppfc_pkg;

    // Action codes carried in the action field of an input item.
    localparam logic [2:0] ACT_READ_RGB    = 3'd0;
    localparam logic [2:0] ACT_READ_GREY   = 3'd1;
    localparam logic [2:0] ACT_WRITE_RGB   = 3'd2;
    localparam logic [2:0] ACT_WRITE_GREY  = 3'd3;
    localparam logic [2:0] ACT_WRITE_INDEX = 3'd4;
    localparam logic [2:0] ACT_READ_INDEX  = 3'd5;

    // Image kinds.
    localparam logic [1:0] KIND_GREY     = 2'd0;
    localparam logic [1:0] KIND_INDEX    = 2'd1;
    localparam logic [1:0] KIND_RGB      = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_WRONG_KIND  = 2'd1;
    localparam logic [1:0] ERR_INDEX_RANGE = 2'd2;
    localparam logic [1:0] ERR_CMAP_ACCESS = 2'd3;

    // Register indexes on the configuration port (byte address is 4 times this).
    localparam logic [2:0] REG_IMAGE_KIND      = 3'd0;
    localparam logic [2:0] REG_PIXEL_DEPTH     = 3'd1;
    localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [2:0] REG_ROW_WIDTH       = 3'd3;
    localparam logic [2:0] REG_COLOR_COUNT     = 3'd4;

    // Register values after reset.
    localparam logic [1:0]  RST_IMAGE_KIND      = KIND_GREY;
    localparam logic [4:0]  RST_PIXEL_DEPTH     = 5'd8;
    localparam logic [1:0]  RST_BYTES_PER_PIXEL = 2'd1;
    localparam logic [12:0] RST_ROW_WIDTH       = 13'd640;
    localparam logic [16:0] RST_COLOR_COUNT     = 17'd256;

    // Luma weights, scaled by 256.
    localparam logic [7:0] WEIGHT_R = 8'd77;
    localparam logic [7:0] WEIGHT_G = 8'd150;
    localparam logic [7:0] WEIGHT_B = 8'd29;

    // Field widths that the work is organized around.
    localparam int BYTE_BITS  = 8;
    localparam int PADDR_BITS = 5;

    // One input item.
    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] pixel_x;
        logic [23:0] stored_bytes;
        logic [23:0] pixel_in;
    } pix_item_t;

    // One result item.
    typedef struct packed {
        logic [23:0] value_out;
        logic [23:0] new_bytes;
        logic        write_valid;
        logic [11:0] address_plane0;
        logic [12:0] address_plane1;
        logic [13:0] address_plane2;
        logic [1:0]  error_code;
    } res_item_t;

    // Configuration registers as seen by the converter.
    typedef struct packed {
        logic [1:0]  image_kind;
        logic [4:0]  pixel_depth;
        logic [1:0]  bytes_per_pixel;
        logic [12:0] row_width;
        logic [16:0] color_count;
    } cfg_t;

endpackage

[rtl/core/ppfc_cfg_regs.sv]
// Configuration register file of the packed pixel format converter.
// APB-style write and read port; uses types and codes from ppfc_pkg.
module ppfc_cfg_regs
    import ppfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_kind      <= RST_IMAGE_KIND;
            cfg_reg.pixel_depth     <= RST_PIXEL_DEPTH;
            cfg_reg.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
            cfg_reg.row_width       <= RST_ROW_WIDTH;
            cfg_reg.color_count     <= RST_COLOR_COUNT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_IMAGE_KIND:      cfg_reg.image_kind      <= pwdata[1:0];
                REG_PIXEL_DEPTH:     cfg_reg.pixel_depth     <= pwdata[4:0];
                REG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= pwdata[1:0];
                REG_ROW_WIDTH:       cfg_reg.row_width       <= pwdata[12:0];
                REG_COLOR_COUNT:     cfg_reg.color_count     <= pwdata[16:0];
                default:             ;
            endcase
        end
    end

    // Read data, zero extended.
    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_KIND:      prdata = {30'd0, cfg_reg.image_kind};
            REG_PIXEL_DEPTH:     prdata = {27'd0, cfg_reg.pixel_depth};
            REG_BYTES_PER_PIXEL: prdata = {30'd0, cfg_reg.bytes_per_pixel};
            REG_ROW_WIDTH:       prdata = {19'd0, cfg_reg.row_width};
            REG_COLOR_COUNT:     prdata = {15'd0, cfg_reg.color_count};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/ppfc_convert.sv]
// Combinational pixel conversion: plane addresses, field unpack and pack,
// grey widening and rgb to grey. Uses types, codes and weights from ppfc_pkg.
module ppfc_convert
    import ppfc_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  cfg_t      cfg,
    input  pix_item_t item,
    output res_item_t res
);

    // Widen a field of d bits to 8 bits by repeating its bits.
    function automatic logic [7:0] widen8(input logic [7:0] v, input logic [3:0] d);
        logic [7:0] w;
        begin
            case (d)
                4'd1:    w = {8{v[0]}};
                4'd2:    w = {4{v[1:0]}};
                4'd3:    w = {v[2:0], v[2:0], v[2:1]};
                4'd4:    w = {2{v[3:0]}};
                4'd5:    w = {v[4:0], v[4:2]};
                4'd6:    w = {v[5:0], v[5:4]};
                4'd7:    w = {v[6:0], v[6]};
                default: w = v;
            endcase
            return w;
        end
    endfunction

    // Weighted luma, reduced to d bits.
    function automatic logic [7:0] rgb_to_grey(input logic [23:0] rgb, input logic [3:0] d);
        logic [16:0] sum;
        logic [7:0]  y;
        logic [3:0]  sh;
        begin
            sum = ({9'd0, WEIGHT_R} * {9'd0, rgb[7:0]})
                + ({9'd0, WEIGHT_G} * {9'd0, rgb[15:8]})
                + ({9'd0, WEIGHT_B} * {9'd0, rgb[23:16]});
            y   = sum[15:8];
            sh  = 4'd8 - d;
            return y >> sh;
        end
    endfunction

    logic [3:0]  depth;
    logic        packed_px;
    logic [1:0]  per_lg;
    logic [2:0]  low_mask;
    logic [2:0]  slot;
    logic [6:0]  shift_prod;
    logic [2:0]  shift;
    logic [7:0]  fmask;
    logic [7:0]  place_mask;
    logic [7:0]  byte0;
    logic [7:0]  field;
    logic [11:0] addr;
    logic [12:0] rw;
    logic [23:0] pmask;
    logic [7:0]  wide_grey;
    logic [7:0]  grey_in;
    logic [7:0]  grey_stored;
    logic [7:0]  pack_val;
    logic [7:0]  packed_byte;
    logic        index_ok;

    // Effective depth and the packing geometry inside a byte.
    always_comb
    begin
        if (cfg.pixel_depth == 5'd0)
            depth = 4'd1;
        else if (cfg.pixel_depth > 5'd8)
            depth = 4'd8;
        else
            depth = cfg.pixel_depth[3:0];

        packed_px = (depth <= 4'd4);
        case (depth)
            4'd1:    per_lg = 2'd3;
            4'd2:    per_lg = 2'd2;
            4'd3,
            4'd4:    per_lg = 2'd1;
            default: per_lg = 2'd0;
        endcase
    end

    // Pixel at x = 0 sits in the highest bits, so the slot counts down.
    assign low_mask   = 3'((4'd1 << per_lg) - 4'd1);
    assign slot       = low_mask & ~item.pixel_x[2:0];
    assign shift_prod = 7'(slot * depth);
    assign shift      = shift_prod[2:0];
    assign fmask      = 8'((9'd1 << depth) - 9'd1);
    assign place_mask = fmask << shift;
    assign byte0      = item.stored_bytes[7:0];
    assign field      = (byte0 >> shift) & fmask;
    assign addr       = item.pixel_x >> per_lg;

    // Row stride, saturated at the largest supported row.
    always_comb
    begin
        if ({19'd0, cfg.row_width} > 32'(MAX_ROW_WIDTH))
            rw = 13'(MAX_ROW_WIDTH);
        else
            rw = cfg.row_width;
    end

    // Bytes that belong to the pixel; zero planes act as one.
    always_comb
    begin
        case (cfg.bytes_per_pixel)
            2'd2:    pmask = 24'h00FFFF;
            2'd3:    pmask = 24'hFFFFFF;
            default: pmask = 24'h0000FF;
        endcase
    end

    assign wide_grey   = widen8(field, depth);
    assign grey_in     = rgb_to_grey(item.pixel_in, depth);
    assign grey_stored = rgb_to_grey(item.stored_bytes & pmask, depth);
    assign index_ok    = {7'd0, cfg.color_count} > item.pixel_in;

    // Value merged into the old byte: converted grey for rgb writes, else the input.
    assign pack_val    = (item.action == ACT_WRITE_RGB) ? grey_in : (item.pixel_in[7:0] & fmask);
    assign packed_byte = (byte0 & ~place_mask) | ((pack_val << shift) & place_mask);

    // Result selection by action and image kind.
    always_comb
    begin
        res.value_out      = 24'd0;
        res.new_bytes      = 24'd0;
        res.write_valid    = 1'b0;
        res.error_code     = ERR_OK;
        res.address_plane0 = addr;
        res.address_plane1 = {1'b0, addr} + rw;
        res.address_plane2 = {2'd0, addr} + {rw, 1'b0};

        if (item.action <= ACT_READ_INDEX && cfg.image_kind == KIND_RESERVED)
        begin
            res.error_code = ERR_WRONG_KIND;
        end
        else
        begin
            case (item.action)
                ACT_READ_RGB:
                begin
                    if (cfg.image_kind == KIND_GREY)
                        res.value_out = {3{wide_grey}};
                    else if (cfg.image_kind == KIND_INDEX)
                        res.error_code = ERR_CMAP_ACCESS;
                    else
                        res.value_out = item.stored_bytes & pmask;
                end
                ACT_READ_GREY:
                begin
                    if (cfg.image_kind == KIND_GREY)
                        res.value_out = {16'd0, field};
                    else if (cfg.image_kind == KIND_INDEX)
                        res.error_code = ERR_CMAP_ACCESS;
                    else
                        res.value_out = {16'd0, grey_stored};
                end
                ACT_WRITE_RGB:
                begin
                    if (cfg.image_kind == KIND_GREY)
                    begin
                        res.new_bytes   = {16'd0, packed_byte};
                        res.write_valid = 1'b1;
                    end
                    else if (cfg.image_kind == KIND_INDEX)
                        res.error_code = ERR_CMAP_ACCESS;
                    else
                    begin
                        res.new_bytes   = item.pixel_in & pmask;
                        res.write_valid = 1'b1;
                    end
                end
                ACT_WRITE_GREY:
                begin
                    if (cfg.image_kind == KIND_GREY)
                    begin
                        res.new_bytes   = {16'd0, packed_byte};
                        res.write_valid = 1'b1;
                    end
                    else if (cfg.image_kind == KIND_INDEX)
                        res.error_code = ERR_CMAP_ACCESS;
                    else
                    begin
                        res.new_bytes   = {3{item.pixel_in[7:0]}} & pmask;
                        res.write_valid = 1'b1;
                    end
                end
                ACT_WRITE_INDEX:
                begin
                    if (cfg.image_kind != KIND_INDEX)
                        res.error_code = ERR_WRONG_KIND;
                    else if (!index_ok)
                        res.error_code = ERR_INDEX_RANGE;
                    else
                    begin
                        res.new_bytes   = packed_px ? {16'd0, packed_byte}
                                                    : (item.pixel_in & pmask);
                        res.write_valid = 1'b1;
                    end
                end
                ACT_READ_INDEX:
                begin
                    if (cfg.image_kind != KIND_INDEX)
                        res.error_code = ERR_WRONG_KIND;
                    else
                        res.value_out = packed_px ? {16'd0, field}
                                                  : (item.stored_bytes & pmask);
                end
                default:
                begin
                    // Unused action codes only report the addresses.
                end
            endcase
        end
    end

endmodule

[rtl/core/packed_pixel_format_converter.sv]
// Top level of the packed pixel format converter.
// Input register, ppfc_convert, result register and ppfc_cfg_regs; uses ppfc_pkg.
//
//   Channel   Direction  Handshake            Payload
//   pix       in         pix_valid/pix_ready  pix_data (pix_item_t)
//   res       out        res_valid/res_ready  res_data (res_item_t)
//   config    in/out     APB psel/penable     paddr, pwdata, prdata
//
// An item is accepted into the input register, and from there the conversion
// logic loads the result register. One item is accepted per cycle while
// results are taken. If res_ready is low, the result register holds and the
// input register takes one more item only if it is empty; then pix_ready
// drops. Reset clears both valid flags and loads register defaults.
module packed_pixel_format_converter
    import ppfc_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pix_item_t             pix_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_item_t             res_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t      cfg;
    pix_item_t pix_reg;
    logic      pix_valid_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      res_valid_reg;
    logic      res_load;

    ppfc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppfc_convert #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_convert (
        .cfg  (cfg),
        .item (pix_reg),
        .res  (res_next)
    );

    // The result register loads when it is empty or being emptied.
    assign res_load  = pix_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready = !pix_valid_reg || res_load;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ready)
                pix_valid_reg <= pix_valid;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
            pix_reg <= pix_data;
        if (res_load)
            res_reg <= res_next;
    end

endmodule
